FILE: rtl/fmpacl_pkg.sv
// Shared types, codes and constants of the first-match prefix ACL unit.
package fmpacl_pkg;

    localparam int unsigned DEF_MAX_RULES = 64;
    localparam int unsigned ADDR_W        = 128;
    localparam int unsigned HALF_W        = 64;
    localparam int unsigned WORD_W        = 32;
    localparam int unsigned LEN_W         = 8;
    localparam int unsigned INDEX_OUT_W   = 6;
    localparam int unsigned V4_LEN        = 32;
    localparam int unsigned V6_LEN        = 128;

    typedef enum logic [1:0] {
        ST_MISS  = 2'd0,
        ST_HIT   = 2'd1,
        ST_ADDED = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [1:0] FAM_IPV4 = 2'd0;
    localparam logic [1:0] FAM_IPV6 = 2'd1;

    localparam logic [0:0] REG_ACL_FAMILY = 1'b0;

    // Request as it travels down the cell chain. For an add, act and flg carry
    // the new rule's words; for a lookup they become the hit's words.
    typedef struct packed {
        logic                is_add;
        logic                live;
        logic                fam;
        t_status             status;
        logic [HALF_W-1:0]   hi;
        logic [HALF_W-1:0]   lo;
        logic [LEN_W-1:0]    plen;
        logic [WORD_W-1:0]   act;
        logic [WORD_W-1:0]   flg;
    } t_req;

endpackage

FILE: rtl/first_match_prefix_acl_unit.sv
// Top level of the first-match IP prefix ACL unit: entry logic, cell chain, APB register.
//
// Requests enter on i_in_valid / o_in_ready with op, address family, address,
// and for an add the prefix length, action and flags. An add appends a rule
// (status added with its index, or table full); a lookup returns the first
// rule in insertion order whose prefix matches (status hit, index, action,
// flags) or a miss. Exactly one result per request leaves on o_out_valid /
// i_out_ready, in request order.
// Each rule lives in one cell of a chain of MAX_RULES cells; a request moves
// one cell per cycle while the chain does not hold, and the result is presented
// from the last cell's register. A new request is taken every cycle unless the
// chain holds. An add writes its cell as it passes, so any later lookup sees it.
// When the receiver stalls with a result waiting, the whole chain holds and
// o_in_ready drops; it rises again once the result is taken.
// The acl_family register sits at APB address 0; the user must write it only while
// the chain is empty, which the block does not enforce. Reset (synchronous, active
// low) empties table and chain, sets acl_family to IPv4; no clearing pass is needed.
module first_match_prefix_acl_unit #(
    parameter int unsigned MAX_RULES = fmpacl_pkg::DEF_MAX_RULES
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [2:0]                            paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_op,
    input  logic [1:0]                            i_addr_family,
    input  logic [fmpacl_pkg::HALF_W-1:0]         i_addr_hi,
    input  logic [fmpacl_pkg::HALF_W-1:0]         i_addr_lo,
    input  logic [fmpacl_pkg::LEN_W-1:0]          i_prefix_len,
    input  logic [fmpacl_pkg::WORD_W-1:0]         i_rule_action,
    input  logic [fmpacl_pkg::WORD_W-1:0]         i_rule_flags,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [1:0]                            o_status,
    output logic [fmpacl_pkg::INDEX_OUT_W-1:0]    o_rule_index,
    output logic [fmpacl_pkg::WORD_W-1:0]         o_hit_action,
    output logic [fmpacl_pkg::WORD_W-1:0]         o_hit_flags
);

    localparam int unsigned CNTW = $clog2(MAX_RULES + 1);
    localparam int unsigned IDXW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int unsigned LAST = MAX_RULES - 1;

    logic                   r_family;
    logic [CNTW-1:0]        r_count;
    logic [CNTW-1:0]        n_count;

    logic                   w_en;
    logic                   w_accept;
    logic                   w_full;
    logic                   w_cfg_wr;
    fmpacl_pkg::t_req       w_entry_req;
    logic [IDXW-1:0]        w_entry_idx;

    logic                   w_valid [MAX_RULES];
    logic [CNTW-1:0]        w_count [MAX_RULES];
    logic [IDXW-1:0]        w_idx   [MAX_RULES];
    fmpacl_pkg::t_req       w_req   [MAX_RULES];

    logic [IDXW+fmpacl_pkg::INDEX_OUT_W-1:0] w_idx_wide;

    // APB register port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == fmpacl_pkg::REG_ACL_FAMILY);
    assign prdata   = (paddr[2] == fmpacl_pkg::REG_ACL_FAMILY) ? {31'd0, r_family} : 32'd0;

    // Entry: build the request from the ports and the current table size.
    assign w_en     = !w_valid[LAST] || i_out_ready;
    assign w_accept = i_in_valid && w_en;
    assign w_full   = (r_count == CNTW'(MAX_RULES));

    always_comb begin
        w_entry_req.is_add = (i_op == fmpacl_pkg::OP_ADD);
        w_entry_req.hi     = i_addr_hi;
        w_entry_req.lo     = i_addr_lo;
        w_entry_req.plen   = i_prefix_len;
        w_entry_req.act    = i_rule_action;
        w_entry_req.flg    = i_rule_flags;
        w_entry_idx        = '0;
        if (i_op == fmpacl_pkg::OP_ADD) begin
            w_entry_req.live   = 1'b0;
            w_entry_req.fam    = r_family;
            w_entry_req.status = w_full ? fmpacl_pkg::ST_FULL : fmpacl_pkg::ST_ADDED;
            if (!w_full) begin
                w_entry_idx = r_count[IDXW-1:0];
            end
        end else begin
            // Other families (bit 1 set) and a mismatch with the table never search.
            w_entry_req.live   = (i_addr_family[1] == 1'b0)
                              && (i_addr_family[0] == r_family);
            w_entry_req.fam    = i_addr_family[0];
            w_entry_req.status = fmpacl_pkg::ST_MISS;
        end
    end

    always_comb begin
        n_count = r_count;
        if (w_accept && (i_op == fmpacl_pkg::OP_ADD) && !w_full) begin
            n_count = r_count + CNTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_family <= 1'b0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_cfg_wr) begin
                r_family <= pwdata[0];
            end
        end
    end

    // Cell chain
    for (genvar g = 0; g < int'(MAX_RULES); g++) begin : g_cell
        if (g == 0) begin : g_head
            fmpacl_cell #(
                .MAX_RULES (MAX_RULES),
                .INDEX     (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en),
                .i_valid (i_in_valid),
                .i_count (r_count),
                .i_idx   (w_entry_idx),
                .i_req   (w_entry_req),
                .o_valid (w_valid[g]),
                .o_count (w_count[g]),
                .o_idx   (w_idx[g]),
                .o_req   (w_req[g])
            );
        end else begin : g_body
            fmpacl_cell #(
                .MAX_RULES (MAX_RULES),
                .INDEX     (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en),
                .i_valid (w_valid[g-1]),
                .i_count (w_count[g-1]),
                .i_idx   (w_idx[g-1]),
                .i_req   (w_req[g-1]),
                .o_valid (w_valid[g]),
                .o_count (w_count[g]),
                .o_idx   (w_idx[g]),
                .o_req   (w_req[g])
            );
        end
    end

    // Result from the last cell
    assign o_in_ready   = w_en;
    assign o_out_valid  = w_valid[LAST];
    assign o_status     = w_req[LAST].status;
    assign w_idx_wide   = {{fmpacl_pkg::INDEX_OUT_W{1'b0}}, w_idx[LAST]};
    assign o_rule_index = w_idx_wide[fmpacl_pkg::INDEX_OUT_W-1:0];
    assign o_hit_action = (w_req[LAST].status == fmpacl_pkg::ST_HIT) ? w_req[LAST].act : '0;
    assign o_hit_flags  = (w_req[LAST].status == fmpacl_pkg::ST_HIT) ? w_req[LAST].flg : '0;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(MAX_RULES))
        else $error("rule count beyond table size");

    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_op == fmpacl_pkg::OP_ADD) && !w_full)
            |=> (r_count == $past(r_count) + CNTW'(1)))
        else $error("accepted add did not grow the table");

    a_count_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_accept && (i_op == fmpacl_pkg::OP_ADD)) |=> $stable(r_count))
        else $error("rule count changed without an add");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_status)))
        else $error("stalled result changed");

endmodule

FILE: rtl/fmpacl_cell.sv
// One rule cell of the ACL chain: holds one rule and checks each passing request.
module fmpacl_cell #(
    parameter  int unsigned MAX_RULES = fmpacl_pkg::DEF_MAX_RULES,
    parameter  int unsigned INDEX     = 0,
    localparam int unsigned CNTW      = $clog2(MAX_RULES + 1),
    localparam int unsigned IDXW      = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [CNTW-1:0]       i_count,
    input  logic [IDXW-1:0]       i_idx,
    input  fmpacl_pkg::t_req      i_req,
    output logic                  o_valid,
    output logic [CNTW-1:0]       o_count,
    output logic [IDXW-1:0]       o_idx,
    output fmpacl_pkg::t_req      o_req
);

    logic                              r_valid;
    logic [CNTW-1:0]                   r_count;
    logic [IDXW-1:0]                   r_idx;
    fmpacl_pkg::t_req                  r_req;

    logic [fmpacl_pkg::HALF_W-1:0]     r_rule_hi;
    logic [fmpacl_pkg::HALF_W-1:0]     r_rule_lo;
    logic [fmpacl_pkg::LEN_W-1:0]      r_rule_len;
    logic                              r_rule_fam;
    logic [fmpacl_pkg::WORD_W-1:0]     r_rule_act;
    logic [fmpacl_pkg::WORD_W-1:0]     r_rule_flg;

    logic [fmpacl_pkg::ADDR_W-1:0]     w_mask;
    logic [fmpacl_pkg::ADDR_W-1:0]     w_diff;
    logic                              w_len_ok;
    logic                              w_hit;
    logic                              w_write;
    fmpacl_pkg::t_req                  n_req;
    logic [IDXW-1:0]                   n_idx;

    // Mask bit for address position b (counted from the top) is set when b < len.
    always_comb begin
        for (int b = 0; b < int'(fmpacl_pkg::ADDR_W); b++) begin
            w_mask[fmpacl_pkg::ADDR_W-1-b] = (fmpacl_pkg::LEN_W'(b) < r_rule_len);
        end
    end

    assign w_diff   = ({r_rule_hi, r_rule_lo} ^ {i_req.hi, i_req.lo}) & w_mask;
    assign w_len_ok = r_rule_fam ? (r_rule_len <= fmpacl_pkg::LEN_W'(fmpacl_pkg::V6_LEN))
                                 : (r_rule_len <= fmpacl_pkg::LEN_W'(fmpacl_pkg::V4_LEN));

    assign w_hit = i_valid && i_req.live && !i_req.is_add
                && (CNTW'(INDEX) < i_count)
                && (r_rule_fam == i_req.fam) && w_len_ok && (w_diff == '0);

    assign w_write = i_en && i_valid && i_req.is_add
                  && (i_req.status == fmpacl_pkg::ST_ADDED) && (i_idx == IDXW'(INDEX));

    always_comb begin
        n_req = i_req;
        n_idx = i_idx;
        if (w_hit) begin
            n_req.live   = 1'b0;
            n_req.status = fmpacl_pkg::ST_HIT;
            n_req.act    = r_rule_act;
            n_req.flg    = r_rule_flg;
            n_idx        = IDXW'(INDEX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_count <= i_count;
            r_idx   <= n_idx;
            r_req   <= n_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_rule_hi  <= i_req.hi;
            r_rule_lo  <= i_req.lo;
            r_rule_len <= i_req.plen;
            r_rule_fam <= i_req.fam;
            r_rule_act <= i_req.act;
            r_rule_flg <= i_req.flg;
        end
    end

    assign o_valid = r_valid;
    assign o_count = r_count;
    assign o_idx   = r_idx;
    assign o_req   = r_req;

endmodule
